### rtl/pfc_pkg.sv
// shared constants, codes and defaults of the partition allocator
// no dependencies; used by the channel interfaces and the top level
package pfc_pkg;

  localparam int unsigned MAX_PARTS_DEF = 16;
  localparam int unsigned ADDR_BITS_DEF = 16;
  localparam int unsigned SIZE_W        = 16;
  localparam int unsigned CMD_W         = 2;
  localparam int unsigned IDX_W         = 4;
  localparam int unsigned STATUS_W      = 3;
  localparam int unsigned COUNT_W       = 5;
  localparam int unsigned CFG_IDX_W     = 2;

  localparam logic              MODE_RST = 1'b0;
  localparam logic [SIZE_W-1:0] RSV_RST  = 16'd120;
  localparam logic [SIZE_W-1:0] POOL_RST = 16'd1000;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT    = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NO_FIT   = 3'd1,
    ST_BAD_SIZE = 3'd2,
    ST_BAD_IDX  = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE = 2'd0,
    CFG_RSV  = 2'd1,
    CFG_POOL = 2'd2
  } cfg_idx_e;

endpackage

### rtl/pfc_if.sv
// valid/ready channel interfaces: request, response and register write
// depends on pfc_pkg for field widths
interface pfc_req_if;
  logic                            valid;
  logic                            ready;
  logic [pfc_pkg::CMD_W-1:0]       command;
  logic [pfc_pkg::SIZE_W-1:0]      req_size;
  logic [pfc_pkg::IDX_W-1:0]       part_index;
  modport source (output valid, command, req_size, part_index, input ready);
  modport sink   (input valid, command, req_size, part_index, output ready);
endinterface

interface pfc_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [pfc_pkg::STATUS_W-1:0]    status;
  logic [pfc_pkg::IDX_W-1:0]       result_index;
  logic [pfc_pkg::SIZE_W-1:0]      result_begin;
  logic [pfc_pkg::SIZE_W-1:0]      result_size;
  logic [pfc_pkg::COUNT_W-1:0]     part_count_out;
  modport source (output valid, status, result_index, result_begin, result_size,
                  part_count_out, input ready);
  modport sink   (input valid, status, result_index, result_begin, result_size,
                  part_count_out, output ready);
endinterface

interface pfc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pfc_pkg::CFG_IDX_W-1:0]   index;
  logic [pfc_pkg::SIZE_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/partition_allocator_fit_coalesce.sv
// partition allocator top level: table memory, scan/shift sequencer, output register
// depends on pfc_pkg and the channel interfaces in pfc_if.sv
//
//  channel | dir | word                                                   | handshake
//  cfg_i   | in  | index, data                                            | valid/ready
//  req_i   | in  | command, req_size, part_index                          | valid/ready
//  rsp_o   | out | status, result_index, result_begin, result_size, count | valid/ready
//
// one word at a time; initialize rewrites the two base entries, allocate scans the table
// and on a split moves the entries above the pick up, release reads the entry and its
// neighbours and moves the entries above the merged one down; bad requests skip the table
// after reset the table is built in S_BUILD0 and S_BUILD1 before req_i.ready rises
// a held response does not stop the next word being taken; it only delays its result
module partition_allocator_fit_coalesce #(
  parameter int unsigned MAX_PARTS = pfc_pkg::MAX_PARTS_DEF,
  parameter int unsigned ADDR_BITS = pfc_pkg::ADDR_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfc_cfg_if.sink   cfg_i,
  pfc_req_if.sink   req_i,
  pfc_rsp_if.source rsp_o
);

  localparam int unsigned IW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int unsigned CW = $clog2(MAX_PARTS + 1);
  localparam int unsigned SW = pfc_pkg::SIZE_W;

  typedef struct packed {
    logic                 used;
    logic [SW-1:0]        size;
    logic [ADDR_BITS-1:0] base;
  } entry_t;

  typedef enum logic [10:0] {
    S_BUILD0 = 11'b00000000001,
    S_BUILD1 = 11'b00000000010,
    S_IDLE   = 11'b00000000100,
    S_SCAN   = 11'b00000001000,
    S_DECIDE = 11'b00000010000,
    S_SHUP   = 11'b00000100000,
    S_SPLIT  = 11'b00001000000,
    S_RDREL  = 11'b00010000000,
    S_MERGE  = 11'b00100000000,
    S_SHDN   = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic          mode_q;
  logic [SW-1:0] rsv_q, pool_q;
  logic          boot_q, boot_d;
  logic [CW-1:0] count_q, count_d;

  logic [SW-1:0] reqsz_q, reqsz_d;
  logic [IW-1:0] pos_q, pos_d;

  logic [CW-1:0] rd_k_q, rd_k_d;
  logic          rd_vld_q;
  logic [1:0]    rd_ph_q;
  logic [IW-1:0] rd_idx_q;
  entry_t        rdata_q;

  logic                 found_q, found_d;
  logic [IW-1:0]        pick_q, pick_d;
  logic [SW-1:0]        pick_sz_q, pick_sz_d;
  logic [ADDR_BITS-1:0] pick_base_q, pick_base_d;

  entry_t        prev_q, prev_d, cur_q, cur_d, next_q, next_d;
  logic [CW-1:0] lim_q, lim_d, dsh_q, dsh_d;

  logic [pfc_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic [IW-1:0]                res_idx_q, res_idx_d;
  logic [SW-1:0]                res_base_q, res_base_d, res_size_q, res_size_d;

  logic                          out_vld_q, out_vld_d;
  logic [pfc_pkg::STATUS_W-1:0]  out_status_q, out_status_d;
  logic [pfc_pkg::IDX_W-1:0]     out_idx_q, out_idx_d;
  logic [SW-1:0]                 out_base_q, out_base_d, out_size_q, out_size_d;
  logic [pfc_pkg::COUNT_W-1:0]   out_count_q, out_count_d;

  entry_t mem_q [MAX_PARTS];

  logic          issue;
  logic [IW-1:0] raddr, waddr;
  logic          we;
  entry_t        wdata;
  logic          hit, has_next, pf, nf;
  logic [SW-1:0] rsv_src, pool_src, msize;
  logic [IW-1:0] tgt;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == S_IDLE);

  assign rsp_o.valid          = out_vld_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.result_index   = out_idx_q;
  assign rsp_o.result_begin   = out_base_q;
  assign rsp_o.result_size    = out_size_q;
  assign rsp_o.part_count_out = out_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= pfc_pkg::MODE_RST;
      rsv_q  <= pfc_pkg::RSV_RST;
      pool_q <= pfc_pkg::POOL_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        pfc_pkg::CFG_MODE: mode_q <= cfg_i.data[0];
        pfc_pkg::CFG_RSV:  rsv_q  <= cfg_i.data;
        pfc_pkg::CFG_POOL: pool_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // table memory, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q  <= mem_q[raddr];
    rd_idx_q <= raddr;
    rd_ph_q  <= rd_k_q[1:0];
  end

  // reset builds the table from the reset register values, not later writes
  assign rsv_src  = boot_q ? pfc_pkg::RSV_RST : rsv_q;
  assign pool_src = boot_q ? pfc_pkg::POOL_RST : pool_q;

  assign hit      = rd_vld_q && !rdata_q.used && (rdata_q.size >= reqsz_q);
  assign has_next = ((CW'(pos_q) + CW'(1)) < count_q);
  assign pf       = (pos_q != IW'(1)) && !prev_q.used;
  assign nf       = has_next && !next_q.used;
  assign msize    = cur_q.size + (nf ? next_q.size : '0) + (pf ? prev_q.size : '0);
  assign tgt      = pf ? (pos_q - IW'(1)) : pos_q;

  always_comb begin
    state_d      = state_q;
    boot_d       = boot_q;
    count_d      = count_q;
    reqsz_d      = reqsz_q;
    pos_d        = pos_q;
    rd_k_d       = rd_k_q;
    found_d      = found_q;
    pick_d       = pick_q;
    pick_sz_d    = pick_sz_q;
    pick_base_d  = pick_base_q;
    prev_d       = prev_q;
    cur_d        = cur_q;
    next_d       = next_q;
    lim_d        = lim_q;
    dsh_d        = dsh_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    res_base_d   = res_base_q;
    res_size_d   = res_size_q;
    out_vld_d    = out_vld_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_idx_d    = out_idx_q;
    out_base_d   = out_base_q;
    out_size_d   = out_size_q;
    out_count_d  = out_count_q;
    issue        = 1'b0;
    raddr        = '0;
    we           = 1'b0;
    waddr        = '0;
    wdata        = '0;

    case (state_q)
      S_BUILD0: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = '{used: 1'b1, size: rsv_src, base: '0};
        state_d = S_BUILD1;
      end
      S_BUILD1: begin
        we      = 1'b1;
        waddr   = IW'(1);
        wdata   = '{used: 1'b0, size: pool_src, base: ADDR_BITS'(rsv_src)};
        count_d = CW'(2);
        boot_d  = 1'b0;
        state_d = boot_q ? S_IDLE : S_DONE;
      end
      S_IDLE: begin
        if (req_i.valid) begin
          reqsz_d      = req_i.req_size;
          pos_d        = IW'(req_i.part_index);
          res_status_d = pfc_pkg::ST_OK;
          res_idx_d    = '0;
          res_base_d   = '0;
          res_size_d   = '0;
          case (req_i.command)
            pfc_pkg::CMD_INIT: state_d = S_BUILD0;
            pfc_pkg::CMD_ALLOC: begin
              if (req_i.req_size == '0) begin
                res_status_d = pfc_pkg::ST_BAD_SIZE;
                state_d      = S_DONE;
              end else begin
                found_d = 1'b0;
                rd_k_d  = CW'(1);
                state_d = S_SCAN;
              end
            end
            pfc_pkg::CMD_RELEASE: begin
              if (req_i.part_index == '0 ||
                  32'(req_i.part_index) >= 32'(count_q)) begin
                res_status_d = pfc_pkg::ST_BAD_IDX;
                state_d      = S_DONE;
              end else begin
                rd_k_d  = '0;
                state_d = S_RDREL;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (hit && (!found_q || (mode_q && rdata_q.size < pick_sz_q))) begin
          found_d     = 1'b1;
          pick_d      = rd_idx_q;
          pick_sz_d   = rdata_q.size;
          pick_base_d = rdata_q.base;
        end
        // first fit stops issuing once a candidate is held
        issue = (rd_k_q < count_q) && (mode_q || !found_q);
        if (issue) begin
          raddr  = rd_k_q[IW-1:0];
          rd_k_d = rd_k_q + CW'(1);
        end
        if (!issue && !rd_vld_q) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_DONE;
        if (!found_q) begin
          res_status_d = pfc_pkg::ST_NO_FIT;
        end else if (pick_sz_q == reqsz_q) begin
          we         = 1'b1;
          waddr      = pick_q;
          wdata      = '{used: 1'b1, size: pick_sz_q, base: pick_base_q};
          res_idx_d  = pick_q;
          res_base_d = SW'(pick_base_q);
          res_size_d = reqsz_q;
        end else if (count_q == CW'(MAX_PARTS)) begin
          res_status_d = pfc_pkg::ST_FULL;
        end else begin
          we         = 1'b1;
          waddr      = pick_q;
          wdata      = '{used: 1'b1, size: reqsz_q, base: pick_base_q};
          res_idx_d  = pick_q;
          res_base_d = SW'(pick_base_q);
          res_size_d = reqsz_q;
          rd_k_d     = count_q - CW'(1);
          state_d    = S_SHUP;
        end
      end
      S_SHUP: begin
        // move entries above the pick one place up, top first
        if (rd_vld_q) begin
          we    = 1'b1;
          waddr = rd_idx_q + IW'(1);
          wdata = rdata_q;
        end
        issue = (rd_k_q > CW'(pick_q));
        if (issue) begin
          raddr  = rd_k_q[IW-1:0];
          rd_k_d = rd_k_q - CW'(1);
        end
        if (!issue && !rd_vld_q) begin
          state_d = S_SPLIT;
        end
      end
      S_SPLIT: begin
        we      = 1'b1;
        waddr   = pick_q + IW'(1);
        wdata   = '{used: 1'b0, size: pick_sz_q - reqsz_q,
                    base: pick_base_q + ADDR_BITS'(reqsz_q)};
        count_d = count_q + CW'(1);
        state_d = S_DONE;
      end
      S_RDREL: begin
        // phases: neighbour below, the entry itself, neighbour above
        if (rd_vld_q) begin
          case (rd_ph_q)
            2'd0:    prev_d = rdata_q;
            2'd1:    cur_d  = rdata_q;
            default: next_d = rdata_q;
          endcase
        end
        if (rd_k_q < CW'(3)) begin
          rd_k_d = rd_k_q + CW'(1);
          case (rd_k_q[1:0])
            2'd0: begin
              issue = 1'b1;
              raddr = pos_q - IW'(1);
            end
            2'd1: begin
              issue = 1'b1;
              raddr = pos_q;
            end
            default: begin
              issue = has_next;
              raddr = has_next ? (pos_q + IW'(1)) : '0;
            end
          endcase
        end else if (!rd_vld_q) begin
          state_d = S_MERGE;
        end
      end
      S_MERGE: begin
        we         = 1'b1;
        waddr      = tgt;
        wdata      = '{used: 1'b0, size: msize, base: pf ? prev_q.base : cur_q.base};
        res_idx_d  = tgt;
        res_base_d = SW'(pf ? prev_q.base : cur_q.base);
        res_size_d = msize;
        dsh_d      = CW'(pf) + CW'(nf);
        lim_d      = count_q;
        count_d    = count_q - (CW'(pf) + CW'(nf));
        rd_k_d     = CW'(tgt) + CW'(1) + CW'(pf) + CW'(nf);
        state_d    = S_SHDN;
      end
      S_SHDN: begin
        // close the gap left by merged entries, bottom first
        if (rd_vld_q) begin
          we    = 1'b1;
          waddr = IW'(CW'(rd_idx_q) - dsh_q);
          wdata = rdata_q;
        end
        issue = (rd_k_q < lim_q);
        if (issue) begin
          raddr  = rd_k_q[IW-1:0];
          rd_k_d = rd_k_q + CW'(1);
        end
        if (!issue && !rd_vld_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d    = 1'b1;
          out_status_d = res_status_q;
          out_idx_d    = pfc_pkg::IDX_W'(res_idx_q);
          out_base_d   = res_base_q;
          out_size_d   = res_size_q;
          out_count_d  = pfc_pkg::COUNT_W'(count_q);
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_BUILD0;
      boot_q    <= 1'b1;
      count_q   <= CW'(2);
      rd_k_q    <= '0;
      rd_vld_q  <= 1'b0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      boot_q    <= boot_d;
      count_q   <= count_d;
      rd_k_q    <= rd_k_d;
      rd_vld_q  <= issue;
      found_q   <= found_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    reqsz_q      <= reqsz_d;
    pos_q        <= pos_d;
    pick_q       <= pick_d;
    pick_sz_q    <= pick_sz_d;
    pick_base_q  <= pick_base_d;
    prev_q       <= prev_d;
    cur_q        <= cur_d;
    next_q       <= next_d;
    lim_q        <= lim_d;
    dsh_q        <= dsh_d;
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    res_base_q   <= res_base_d;
    res_size_q   <= res_size_d;
    out_status_q <= out_status_d;
    out_idx_q    <= out_idx_d;
    out_base_q   <= out_base_d;
    out_size_q   <= out_size_d;
    out_count_q  <= out_count_d;
  end

endmodule

### dv/partition_allocator_fit_coalesce_tb.sv
// testbench for the partition allocator: directed and random commands, checked against
// a behavioural copy of the partition table; needs pfc_pkg, pfc_if.sv and the top level
module partition_allocator_fit_coalesce_tb;

  localparam int NPARTS   = pfc_pkg::MAX_PARTS_DEF;
  localparam int WD_LIMIT = 20000;

  typedef struct packed {
    logic [pfc_pkg::STATUS_W-1:0] status;
    logic [pfc_pkg::IDX_W-1:0]    index;
    logic [pfc_pkg::SIZE_W-1:0]   begin_addr;
    logic [pfc_pkg::SIZE_W-1:0]   size;
    logic [pfc_pkg::COUNT_W-1:0]  count;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pfc_cfg_if cfg ();
  pfc_req_if req ();
  pfc_rsp_if rsp ();

  partition_allocator_fit_coalesce DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg),
    .req_i (req),
    .rsp_o (rsp)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow table
  logic                       mode_q;
  logic [pfc_pkg::SIZE_W-1:0] rsv_q, pool_q;
  logic [15:0]      tb_begin [NPARTS];
  logic [15:0]      tb_size  [NPARTS];
  logic             tb_used  [NPARTS];
  int               tb_count;

  outcome_t expected_q[$];
  int errors = 0;
  int send_idle = 0, recv_idle = 0;
  int wd_cycles = 0;

  task automatic rebuild_table();
    for (int k = 0; k < NPARTS; k++) begin
      tb_begin[k] = '0; tb_size[k] = '0; tb_used[k] = 1'b0;
    end
    tb_size[0] = rsv_q; tb_used[0] = 1'b1;
    tb_begin[1] = rsv_q; tb_size[1] = pool_q;
    tb_count = 2;
  endtask

  task automatic drop_entry(int pos);
    for (int k = pos; k + 1 < tb_count; k++) begin
      tb_begin[k] = tb_begin[k+1]; tb_size[k] = tb_size[k+1]; tb_used[k] = tb_used[k+1];
    end
    tb_count--;
  endtask

  task automatic predict_outcome(logic [pfc_pkg::CMD_W-1:0] c, logic [15:0] rs,
                                 logic [3:0] pi);
    outcome_t o;
    pfc_pkg::status_e st;
    int pick, pos;
    st = pfc_pkg::ST_OK; pos = -1; pick = -1;
    if (c == pfc_pkg::CMD_INIT) begin
      rebuild_table();
    end else if (c == pfc_pkg::CMD_ALLOC) begin
      if (rs == 0) begin
        st = pfc_pkg::ST_BAD_SIZE;
      end else begin
        for (int k = 1; k < tb_count; k++) begin
          if (!tb_used[k] && tb_size[k] >= rs) begin
            if (pick < 0) begin
              pick = k;
              if (mode_q == 1'b0) break;
            end else if (tb_size[k] < tb_size[pick]) begin
              pick = k;
            end
          end
        end
        if (pick < 0) begin
          st = pfc_pkg::ST_NO_FIT;
        end else if (tb_size[pick] == rs) begin
          tb_used[pick] = 1'b1; pos = pick;
        end else if (tb_count >= NPARTS) begin
          st = pfc_pkg::ST_FULL;
        end else begin
          for (int k = tb_count; k > pick; k--) begin
            tb_begin[k] = tb_begin[k-1]; tb_size[k] = tb_size[k-1]; tb_used[k] = tb_used[k-1];
          end
          tb_count++;
          tb_size[pick] = rs; tb_used[pick] = 1'b1;
          tb_begin[pick+1] = tb_begin[pick] + rs;
          tb_size[pick+1] = tb_size[pick+1] - rs;
          tb_used[pick+1] = 1'b0;
          pos = pick;
        end
      end
    end else if (c == pfc_pkg::CMD_RELEASE) begin
      pos = int'(pi);
      if (pos < 1 || pos >= tb_count) begin
        st = pfc_pkg::ST_BAD_IDX; pos = -1;
      end else begin
        tb_used[pos] = 1'b0;
        if (pos + 1 < tb_count && !tb_used[pos+1]) begin
          tb_size[pos] = tb_size[pos] + tb_size[pos+1];
          drop_entry(pos + 1);
        end
        if (pos - 1 >= 1 && !tb_used[pos-1]) begin
          tb_size[pos-1] = tb_size[pos-1] + tb_size[pos];
          drop_entry(pos);
          pos--;
        end
      end
    end
    o = '0;
    o.status = st;
    if (st == pfc_pkg::ST_OK && pos >= 0) begin
      o.index = pfc_pkg::IDX_W'(pos); o.begin_addr = tb_begin[pos]; o.size = tb_size[pos];
    end
    o.count = pfc_pkg::COUNT_W'(tb_count);
    expected_q.push_back(o);
  endtask

  // every caller returns at a falling edge; wait one more so valid drops for a cycle
  task automatic send_word(logic [pfc_pkg::CMD_W-1:0] c, logic [15:0] rs, logic [3:0] pi);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) @(negedge clk_i);
    req.valid <= 1'b1; req.command <= c; req.req_size <= rs; req.part_index <= pi;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    predict_outcome(c, rs, pi);
    @(negedge clk_i);
    req.valid <= 1'b0;
  endtask

  task automatic write_reg(pfc_pkg::cfg_idx_e idx, logic [15:0] d);
    @(negedge clk_i);
    cfg.valid <= 1'b1; cfg.index <= idx; cfg.data <= d;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    case (idx)
      pfc_pkg::CFG_MODE: mode_q = d[0];
      pfc_pkg::CFG_RSV:  rsv_q = d;
      default:           pool_q = d;
    endcase
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  // response checker
  always @(posedge clk_i) begin
    outcome_t got, exp_o;
    if (rsp.valid && rsp.ready) begin
      got = {rsp.status, rsp.result_index, rsp.result_begin, rsp.result_size,
             rsp.part_count_out};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, got);
        errors++;
      end else begin
        exp_o = expected_q.pop_front();
        if (got.status !== exp_o.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_o.status, got.status);
          errors++;
        end
        if (got.index !== exp_o.index) begin
          $display("%0t: index expected %0d actual %0d", $time, exp_o.index, got.index);
          errors++;
        end
        if (got.begin_addr !== exp_o.begin_addr) begin
          $display("%0t: begin expected %0d actual %0d", $time, exp_o.begin_addr,
                   got.begin_addr);
          errors++;
        end
        if (got.size !== exp_o.size) begin
          $display("%0t: size expected %0d actual %0d", $time, exp_o.size, got.size);
          errors++;
        end
        if (got.count !== exp_o.count) begin
          $display("%0t: count expected %0d actual %0d", $time, exp_o.count, got.count);
          errors++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    rsp.ready <= ($urandom_range(99) >= recv_idle);
  end

  // watchdog on accepted words
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready)) begin
      wd_cycles <= 0;
    end else if (wd_cycles >= WD_LIMIT) begin
      $display("partition_allocator_fit_coalesce_tb: errors");
      $finish;
    end else begin
      wd_cycles <= wd_cycles + 1;
    end
  end

  task automatic test_reset_table();
    send_word(pfc_pkg::CMD_ALLOC, 16'd100, 4'd0);
    send_word(pfc_pkg::CMD_ALLOC, 16'd0, 4'd0);
    send_word(pfc_pkg::CMD_ALLOC, 16'hFFFF, 4'd0);
    send_word(pfc_pkg::CMD_RELEASE, 16'd0, 4'd0);
    send_word(pfc_pkg::CMD_RELEASE, 16'd0, 4'd15);
    send_word(pfc_pkg::CMD_RELEASE, 16'd0, 4'd1);
    send_word(2'd3, 16'hFFFF, 4'hF);
    drain();
  endtask

  task automatic test_fill_and_coalesce();
    write_reg(pfc_pkg::CFG_MODE, 16'd1);
    write_reg(pfc_pkg::CFG_RSV, 16'hFFF0);
    write_reg(pfc_pkg::CFG_POOL, 16'hFFFF);
    send_word(pfc_pkg::CMD_INIT, 16'd0, 4'd0);
    for (int k = 0; k < 15; k++) send_word(pfc_pkg::CMD_ALLOC, 16'd3, 4'd0);   // hits table full
    send_word(pfc_pkg::CMD_RELEASE, 16'd0, 4'd2);
    send_word(pfc_pkg::CMD_RELEASE, 16'd0, 4'd4);
    send_word(pfc_pkg::CMD_RELEASE, 16'd0, 4'd3);   // merges on both sides
    send_word(pfc_pkg::CMD_RELEASE, 16'd0, 4'd2);   // already free
    send_word(pfc_pkg::CMD_ALLOC, 16'd9, 4'd0);      // exact fit
    drain();
    write_reg(pfc_pkg::CFG_POOL, 16'd0);
    send_word(pfc_pkg::CMD_INIT, 16'd0, 4'd0);
    send_word(pfc_pkg::CMD_ALLOC, 16'd1, 4'd0);
    drain();
    write_reg(pfc_pkg::CFG_RSV, 16'd0);
    write_reg(pfc_pkg::CFG_POOL, 16'd1);
    write_reg(pfc_pkg::CFG_MODE, 16'd0);
    send_word(pfc_pkg::CMD_INIT, 16'd0, 4'd0);
    send_word(pfc_pkg::CMD_ALLOC, 16'd1, 4'd0);
    drain();
  endtask

  task automatic test_random_traffic(int n);
    logic [pfc_pkg::CMD_W-1:0] c;
    logic [15:0] rs;
    int r;
    for (int i = 0; i < n; i++) begin
      if (i % 200 == 0) begin
        drain();
        write_reg(pfc_pkg::CFG_MODE, 16'($urandom_range(1)));
        write_reg(pfc_pkg::CFG_RSV, ($urandom_range(3) == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(500)));
        write_reg(pfc_pkg::CFG_POOL, ($urandom_range(4) == 0) ? 16'($urandom_range(65535, 1))
                                                              : 16'($urandom_range(2000, 1)));
        send_word(pfc_pkg::CMD_INIT, 16'($urandom), 4'($urandom));
        continue;
      end
      r = $urandom_range(99);
      c = (r < 50) ? pfc_pkg::CMD_ALLOC : (r < 94) ? pfc_pkg::CMD_RELEASE :
          (r < 97) ? pfc_pkg::CMD_INIT : 2'd3;
      rs = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(pool_q / 4 + 1));
      send_word(c, rs, ($urandom_range(4) == 0) ? 4'($urandom) : 4'($urandom_range(tb_count)));
    end
    drain();
  endtask

  initial begin
    cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
    req.valid = 1'b0; req.command = '0; req.req_size = '0; req.part_index = '0;
    rsp.ready = 1'b0;
    mode_q = pfc_pkg::MODE_RST; rsv_q = pfc_pkg::RSV_RST; pool_q = pfc_pkg::POOL_RST;
    rebuild_table();
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    send_idle = 18; recv_idle = 71;
    test_reset_table();
    test_fill_and_coalesce();
    test_random_traffic(600);
    send_idle = 71; recv_idle = 18;
    test_random_traffic(600);
    send_idle = 0; recv_idle = 0;
    test_random_traffic(650);
    if (errors == 0) begin
      $display("partition_allocator_fit_coalesce_tb: clean");
    end else begin
      $display("partition_allocator_fit_coalesce_tb: errors");
    end
    $finish;
  end

endmodule

### files.f
rtl/pfc_pkg.sv
rtl/pfc_if.sv
rtl/partition_allocator_fit_coalesce.sv
dv/partition_allocator_fit_coalesce_tb.sv
